### design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Each macro takes a label, the clock, the active-low reset, the antecedent,
// the consequent and the message that is reported on failure.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/evg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_pkg
// Types, constants and the arctangent table of the ellipse vertex generator.
// ----------------------------------------------------------------------------
package evg_pkg;

    localparam int MAX_VERTICES   = 256;
    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int PIPE_DEPTH     = CORDIC_STAGES + 4;
    localparam int INFLIGHT_W     = $clog2(PIPE_DEPTH + 1);

    localparam int IDX_W    = 9;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int TOTAL_W  = 10;
    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 16;
    localparam int XY_W     = 34;
    localparam int Z_W      = 33;
    localparam int STAGE_W  = 5;
    localparam int PROD_W   = XY_W + SIZE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]  MAX_COUNT        = COUNT_W'(MAX_VERTICES);
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INIT = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] Q30_ONE          = XY_W'(1073741824);

    typedef logic signed [Z_W-1:0] t_atan_table [ATAN_ENTRIES];

    localparam t_atan_table ATAN_TURNS = '{
        Z_W'(536870912), Z_W'(316933406), Z_W'(167458907), Z_W'(85004756),
        Z_W'(42667331),  Z_W'(21354465),  Z_W'(10679838),  Z_W'(5340245),
        Z_W'(2670163),   Z_W'(1335087),   Z_W'(667544),    Z_W'(333772),
        Z_W'(166886),    Z_W'(83443),     Z_W'(41722),     Z_W'(20861),
        Z_W'(10430),     Z_W'(5215),      Z_W'(2608),      Z_W'(1304),
        Z_W'(652),       Z_W'(326),       Z_W'(163),       Z_W'(81)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTER_WIDTH  = 3'd0,
        REG_OUTER_HEIGHT = 3'd1,
        REG_INNER_WIDTH  = 3'd2,
        REG_INNER_HEIGHT = 3'd3,
        REG_VERTEX_COUNT = 3'd4,
        REG_PHASE_STEP   = 3'd5,
        REG_SHAPE_MODE   = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SHAPE_ELLIPSE = 2'd0,
        SHAPE_DISK    = 2'd1,
        SHAPE_RING    = 2'd2,
        SHAPE_RECT    = 2'd3
    } t_shape;

    typedef struct packed {
        logic [SIZE_W-1:0]  outer_width;
        logic [SIZE_W-1:0]  outer_height;
        logic [SIZE_W-1:0]  inner_width;
        logic [SIZE_W-1:0]  inner_height;
        logic [COUNT_W-1:0] vertex_count;
        logic [ANGLE_W-1:0] phase_step;
        t_shape             shape_mode;
    } t_cfg;

    typedef struct packed {
        logic              valid_res;
        logic              last;
        logic              rect;
        logic              cx_pos;
        logic              sy_pos;
        logic [1:0]        quad;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_meta;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [STAGE_W-1:0] stage);
        logic signed [Z_W-1:0] val;
        val = '0;
        if (int'(stage) < ATAN_ENTRIES) begin
            val = ATAN_TURNS[stage];
        end
        return val;
    endfunction

endpackage

### design/evg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_req_if
// Request channel: one vertex index per word.
// ----------------------------------------------------------------------------
interface evg_req_if;
    logic                           valid;
    logic                           ready;
    logic [evg_pkg::IDX_W-1:0]      vertex_index;

    modport source (output valid, output vertex_index, input ready);
    modport sink   (input valid, input vertex_index, output ready);
endinterface

### design/evg_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_res_if
// Result channel: one polygon vertex per word.
// ----------------------------------------------------------------------------
interface evg_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [evg_pkg::COORD_W-1:0]  vertex_x;
    logic signed [evg_pkg::COORD_W-1:0]  vertex_y;
    logic                                valid_res;
    logic                                last;

    modport source (output valid, output vertex_x, output vertex_y,
                    output valid_res, output last, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y,
                    input valid_res, input last, output ready);
endinterface

### design/evg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_front
// Decodes the vertex index against the shape, forms the angle and splits it
// into a quadrant and a residue for the rotation chain.
// ----------------------------------------------------------------------------
module evg_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  evg_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [evg_pkg::IDX_W-1:0]           i_vertex_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [evg_pkg::Z_W-1:0]      o_z,
    output evg_pkg::t_meta                      o_meta
);

    logic                                r_valid;
    logic signed [evg_pkg::Z_W-1:0]      r_z;
    evg_pkg::t_meta                      r_meta;

    logic [evg_pkg::COUNT_W-1:0]         n_count;
    logic [evg_pkg::TOTAL_W-1:0]         n_total;
    logic [evg_pkg::TOTAL_W-1:0]         n_idx_ext;
    logic [evg_pkg::IDX_W-1:0]           n_k;
    logic                                n_inner;
    logic [evg_pkg::IDX_W+evg_pkg::ANGLE_W-1:0] n_prod;
    logic [evg_pkg::ANGLE_W-1:0]         n_angle;
    logic [evg_pkg::ANGLE_W-1:0]         n_round;
    logic [1:0]                          n_quad;
    logic [evg_pkg::ANGLE_W-1:0]         n_res;
    logic signed [evg_pkg::Z_W-1:0]      n_z;
    evg_pkg::t_meta                      n_meta;

    always_comb begin
        n_count = (i_cfg.vertex_count > evg_pkg::MAX_COUNT) ? evg_pkg::MAX_COUNT
                                                            : i_cfg.vertex_count;
        case (i_cfg.shape_mode)
            evg_pkg::SHAPE_ELLIPSE: begin
                n_total = evg_pkg::TOTAL_W'(n_count);
            end
            evg_pkg::SHAPE_DISK: begin
                n_total = (n_count != '0) ? evg_pkg::TOTAL_W'(n_count) - 1'b1 : '0;
            end
            evg_pkg::SHAPE_RING: begin
                n_total = (n_count != '0) ? {n_count - 1'b1, 1'b0} : '0;
            end
            default: begin
                n_total = evg_pkg::TOTAL_W'(4);
            end
        endcase

        n_idx_ext = evg_pkg::TOTAL_W'(i_vertex_index);
        n_inner   = (i_cfg.shape_mode == evg_pkg::SHAPE_RING) && !i_vertex_index[0];
        n_k       = (i_cfg.shape_mode == evg_pkg::SHAPE_RING)
                  ? {1'b0, i_vertex_index[evg_pkg::IDX_W-1:1]} : i_vertex_index;
        n_prod    = n_k * i_cfg.phase_step;
        n_angle   = n_prod[evg_pkg::ANGLE_W-1:0];
        n_round   = n_angle + evg_pkg::ANGLE_W'(16'h2000);
        n_quad    = n_round[evg_pkg::ANGLE_W-1:evg_pkg::ANGLE_W-2];
        n_res     = n_angle - {n_quad, 14'b0};
        n_z       = $signed({n_res[evg_pkg::ANGLE_W-1], n_res, 16'b0});

        n_meta.valid_res = n_idx_ext < n_total;
        n_meta.last      = n_meta.valid_res && (n_idx_ext == n_total - 1'b1);
        n_meta.rect      = i_cfg.shape_mode == evg_pkg::SHAPE_RECT;
        n_meta.cx_pos    = i_vertex_index >= evg_pkg::IDX_W'(2);
        n_meta.sy_pos    = (i_vertex_index == evg_pkg::IDX_W'(1))
                        || (i_vertex_index == evg_pkg::IDX_W'(2));
        n_meta.quad      = n_quad;
        n_meta.width     = n_inner ? i_cfg.inner_width : i_cfg.outer_width;
        n_meta.height    = n_inner ? i_cfg.inner_height : i_cfg.outer_height;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_z    <= n_z;
            r_meta <= n_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_meta  = r_meta;

endmodule

### design/evg_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_cordic_cell
// One rotation step of the sine-cosine chain, with its own pipeline register.
// ----------------------------------------------------------------------------
module evg_cordic_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [evg_pkg::STAGE_W-1:0]         i_stage,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [evg_pkg::XY_W-1:0]     i_x,
    input  logic signed [evg_pkg::XY_W-1:0]     i_y,
    input  logic signed [evg_pkg::Z_W-1:0]      i_z,
    input  evg_pkg::t_meta                      i_meta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [evg_pkg::XY_W-1:0]     o_x,
    output logic signed [evg_pkg::XY_W-1:0]     o_y,
    output logic signed [evg_pkg::Z_W-1:0]      o_z,
    output evg_pkg::t_meta                      o_meta
);

    logic                                r_valid;
    logic signed [evg_pkg::XY_W-1:0]     r_x;
    logic signed [evg_pkg::XY_W-1:0]     r_y;
    logic signed [evg_pkg::Z_W-1:0]      r_z;
    evg_pkg::t_meta                      r_meta;

    logic signed [evg_pkg::XY_W-1:0]     n_xs;
    logic signed [evg_pkg::XY_W-1:0]     n_ys;
    logic signed [evg_pkg::Z_W-1:0]      n_atan;
    logic signed [evg_pkg::XY_W-1:0]     n_x;
    logic signed [evg_pkg::XY_W-1:0]     n_y;
    logic signed [evg_pkg::Z_W-1:0]      n_z;

    always_comb begin
        n_xs   = i_x >>> i_stage;
        n_ys   = i_y >>> i_stage;
        n_atan = evg_pkg::atan_step(i_stage);
        if (!i_z[evg_pkg::Z_W-1]) begin
            n_x = i_x - n_ys;
            n_y = i_y + n_xs;
            n_z = i_z - n_atan;
        end else begin
            n_x = i_x + n_ys;
            n_y = i_y - n_xs;
            n_z = i_z + n_atan;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_meta  = r_meta;

endmodule

### design/evg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evg_back
// Rotates cosine and sine into their quadrant, scales them by the shape size,
// rounds and saturates, and holds the result word for the sink.
// ----------------------------------------------------------------------------
module evg_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [evg_pkg::XY_W-1:0]     i_x,
    input  logic signed [evg_pkg::XY_W-1:0]     i_y,
    input  evg_pkg::t_meta                      i_meta,
    evg_res_if.source                           o_res
);

    logic                                   r_a_valid;
    logic signed [evg_pkg::XY_W-1:0]        r_a_c;
    logic signed [evg_pkg::XY_W-1:0]        r_a_s;
    evg_pkg::t_meta                         r_a_meta;

    logic                                   r_b_valid;
    logic signed [evg_pkg::PROD_W-1:0]      r_b_px;
    logic signed [evg_pkg::PROD_W-1:0]      r_b_py;
    logic                                   r_b_valid_res;
    logic                                   r_b_last;

    logic                                   r_c_valid;
    logic signed [evg_pkg::COORD_W-1:0]     r_c_x;
    logic signed [evg_pkg::COORD_W-1:0]     r_c_y;
    logic                                   r_c_valid_res;
    logic                                   r_c_last;

    logic                                   n_a_ready;
    logic                                   n_b_ready;
    logic                                   n_c_ready;
    logic signed [evg_pkg::XY_W-1:0]        n_c;
    logic signed [evg_pkg::XY_W-1:0]        n_s;
    logic signed [evg_pkg::PROD_W-1:0]      n_px;
    logic signed [evg_pkg::PROD_W-1:0]      n_py;
    logic signed [evg_pkg::COORD_W-1:0]     n_x;
    logic signed [evg_pkg::COORD_W-1:0]     n_y;

    function automatic logic signed [evg_pkg::COORD_W-1:0] round_sat(
        input logic signed [evg_pkg::PROD_W-1:0] prod
    );
        logic signed [evg_pkg::PROD_W:0]                     sum;
        logic signed [evg_pkg::PROD_W-31:0]                  quo;
        logic signed [evg_pkg::COORD_W-1:0]                  res;
        sum = {prod[evg_pkg::PROD_W-1], prod} + (evg_pkg::PROD_W+1)'(1073741824);
        quo = sum[evg_pkg::PROD_W:31];
        if (quo > (evg_pkg::PROD_W-30)'(32767)) begin
            res = 16'sh7fff;
        end else if (quo < -(evg_pkg::PROD_W-30)'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = quo[evg_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    assign n_c_ready = !r_c_valid || o_res.ready;
    assign n_b_ready = !r_b_valid || n_c_ready;
    assign n_a_ready = !r_a_valid || n_b_ready;
    assign o_ready   = n_a_ready;

    always_comb begin
        case (i_meta.quad)
            2'd0: begin
                n_c = i_x;
                n_s = i_y;
            end
            2'd1: begin
                n_c = -i_y;
                n_s = i_x;
            end
            2'd2: begin
                n_c = -i_x;
                n_s = -i_y;
            end
            default: begin
                n_c = i_y;
                n_s = -i_x;
            end
        endcase
        if (i_meta.rect) begin
            n_c = i_meta.cx_pos ? evg_pkg::Q30_ONE : -evg_pkg::Q30_ONE;
            n_s = i_meta.sy_pos ? evg_pkg::Q30_ONE : -evg_pkg::Q30_ONE;
        end
    end

    assign n_px = r_a_c * $signed({1'b0, r_a_meta.width});
    assign n_py = r_a_s * $signed({1'b0, r_a_meta.height});
    assign n_x  = r_b_valid_res ? round_sat(r_b_px) : '0;
    assign n_y  = r_b_valid_res ? round_sat(r_b_py) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (n_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (n_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (n_c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_a_ready && i_valid) begin
            r_a_c    <= n_c;
            r_a_s    <= n_s;
            r_a_meta <= i_meta;
        end
        if (n_b_ready && r_a_valid) begin
            r_b_px        <= n_px;
            r_b_py        <= n_py;
            r_b_valid_res <= r_a_meta.valid_res;
            r_b_last      <= r_a_meta.last;
        end
        if (n_c_ready && r_b_valid) begin
            r_c_x         <= n_x;
            r_c_y         <= n_y;
            r_c_valid_res <= r_b_valid_res;
            r_c_last      <= r_b_valid_res && r_b_last;
        end
    end

    assign o_res.valid     = r_c_valid;
    assign o_res.vertex_x  = r_c_x;
    assign o_res.vertex_y  = r_c_y;
    assign o_res.valid_res = r_c_valid_res;
    assign o_res.last      = r_c_last;

endmodule

### design/ellipse_vertex_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_vertex_generator_unit
// Generates one polygon vertex of an ellipse, disk, ring or rectangle for
// each requested vertex index, using a pipelined rotation chain.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  i_req     in         vertex_index
//  o_res     out        vertex_x, vertex_y, valid_res, last
//  i_cfg_*   in         register index and data, written when i_cfg_we is high
//
// One word is taken every cycle unless the sink stalls. The stages are one
// decode stage, one cell per rotation step, then rotate, scale and round
// stages. Every stage takes a new word when it is empty or when its
// successor moves, so bubbles close up and a stalled sink backs up the chain.
// Reset is synchronous and clears the stage valid bits, the configuration and the in-flight count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ellipse_vertex_generator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [evg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [evg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    evg_req_if.sink                             i_req,
    evg_res_if.source                           o_res
);

    evg_pkg::t_cfg                              r_cfg;
    logic [evg_pkg::INFLIGHT_W-1:0]             r_inflight;
    logic [evg_pkg::INFLIGHT_W-1:0]             n_inflight;

    logic                                       front_valid;
    logic                                       front_ready;
    logic signed [evg_pkg::Z_W-1:0]             front_z;
    evg_pkg::t_meta                             front_meta;

    logic                                       chain_valid [evg_pkg::CORDIC_STAGES+1];
    logic                                       chain_ready [evg_pkg::CORDIC_STAGES+1];
    logic signed [evg_pkg::XY_W-1:0]            chain_x     [evg_pkg::CORDIC_STAGES+1];
    logic signed [evg_pkg::XY_W-1:0]            chain_y     [evg_pkg::CORDIC_STAGES+1];
    logic signed [evg_pkg::Z_W-1:0]             chain_z     [evg_pkg::CORDIC_STAGES+1];
    evg_pkg::t_meta                             chain_meta  [evg_pkg::CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_width  <= '0;
            r_cfg.outer_height <= '0;
            r_cfg.inner_width  <= '0;
            r_cfg.inner_height <= '0;
            r_cfg.vertex_count <= evg_pkg::COUNT_W'(1);
            r_cfg.phase_step   <= '0;
            r_cfg.shape_mode   <= evg_pkg::SHAPE_ELLIPSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                evg_pkg::REG_OUTER_WIDTH: begin
                    r_cfg.outer_width <= i_cfg_data;
                end
                evg_pkg::REG_OUTER_HEIGHT: begin
                    r_cfg.outer_height <= i_cfg_data;
                end
                evg_pkg::REG_INNER_WIDTH: begin
                    r_cfg.inner_width <= i_cfg_data;
                end
                evg_pkg::REG_INNER_HEIGHT: begin
                    r_cfg.inner_height <= i_cfg_data;
                end
                evg_pkg::REG_VERTEX_COUNT: begin
                    r_cfg.vertex_count <= i_cfg_data[evg_pkg::COUNT_W-1:0];
                end
                evg_pkg::REG_PHASE_STEP: begin
                    r_cfg.phase_step <= i_cfg_data;
                end
                evg_pkg::REG_SHAPE_MODE: begin
                    r_cfg.shape_mode <= evg_pkg::t_shape'(i_cfg_data[1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    evg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_req.valid),
        .o_ready        (i_req.ready),
        .i_vertex_index (i_req.vertex_index),
        .o_valid        (front_valid),
        .i_ready        (front_ready),
        .o_z            (front_z),
        .o_meta         (front_meta)
    );

    assign chain_valid[0] = front_valid;
    assign front_ready    = chain_ready[0];
    assign chain_x[0]     = evg_pkg::CORDIC_GAIN_INIT;
    assign chain_y[0]     = '0;
    assign chain_z[0]     = front_z;
    assign chain_meta[0]  = front_meta;

    for (genvar g = 0; g < evg_pkg::CORDIC_STAGES; g++) begin : g_cell
        evg_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (evg_pkg::STAGE_W'(g)),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_x     (chain_x[g]),
            .i_y     (chain_y[g]),
            .i_z     (chain_z[g]),
            .i_meta  (chain_meta[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_x     (chain_x[g+1]),
            .o_y     (chain_y[g+1]),
            .o_z     (chain_z[g+1]),
            .o_meta  (chain_meta[g+1])
        );
    end

    evg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[evg_pkg::CORDIC_STAGES]),
        .o_ready (chain_ready[evg_pkg::CORDIC_STAGES]),
        .i_x     (chain_x[evg_pkg::CORDIC_STAGES]),
        .i_y     (chain_y[evg_pkg::CORDIC_STAGES]),
        .i_meta  (chain_meta[evg_pkg::CORDIC_STAGES]),
        .o_res   (o_res)
    );

    always_comb begin
        n_inflight = r_inflight;
        if (i_req.valid && i_req.ready) begin
            n_inflight = n_inflight + 1'b1;
        end
        if (o_res.valid && o_res.ready) begin
            n_inflight = n_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `ASSERT_IMPLIES(a_inflight_bound, i_clk, i_rst_n, 1'b1,
        r_inflight <= evg_pkg::INFLIGHT_W'(evg_pkg::PIPE_DEPTH),
        "more words in flight than pipeline stages")
    `ASSERT_IMPLIES(a_out_has_source, i_clk, i_rst_n, o_res.valid,
        r_inflight != '0, "result word without an accepted request")
    `ASSERT_IMPLIES(a_invalid_zero, i_clk, i_rst_n, o_res.valid && !o_res.valid_res,
        o_res.vertex_x == '0 && o_res.vertex_y == '0 && !o_res.last,
        "out-of-range vertex carries nonzero fields")
    `ASSERT_NEXT(a_full_blocks_input, i_clk, i_rst_n,
        r_inflight == evg_pkg::INFLIGHT_W'(evg_pkg::PIPE_DEPTH) && !o_res.ready,
        !(i_req.valid && i_req.ready) || r_inflight != evg_pkg::INFLIGHT_W'(evg_pkg::PIPE_DEPTH)
        || o_res.ready, "request accepted while every stage is full")

endmodule
